/* src/mjm_pkg.sv */
// Shared types and constants for the mecanum joystick mixer.
// Used by the front end, the normalizer and the top level; depends on nothing else.
package mjm_pkg;

   localparam int AXIS_W        = 11;
   localparam int ABS_W         = 11;
   localparam int SUM_W         = 13;
   localparam int MAG_W         = 12;
   localparam int DZ_W          = 10;
   localparam int PWM_W         = 16;
   localparam int DUTY_W        = 16;
   localparam int NUM_WHEELS    = 4;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int MIX_LIMIT_DEF = 512;

   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SNAP_LEVEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_FULL   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT     = 2'd3;

   localparam logic [DZ_W-1:0]       DEAD_ZONE_RST  = 10'd50;
   localparam logic [DZ_W-1:0]       SNAP_LEVEL_RST = 10'd150;
   localparam logic [PWM_W-1:0]      PWM_FULL_RST   = 16'd1000;
   localparam logic [NUM_WHEELS-1:0] INVERT_RST     = 4'd0;

   localparam int WHEEL_FL = 0;
   localparam int WHEEL_FR = 1;
   localparam int WHEEL_RL = 2;
   localparam int WHEEL_RR = 3;

   typedef struct packed {
      logic [DZ_W-1:0]       dead_zone;
      logic [DZ_W-1:0]       snap_level;
      logic [PWM_W-1:0]      pwm_full_scale;
      logic [NUM_WHEELS-1:0] invert_mask;
   } cfg_type;

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [MAG_W-1:0]        mag_type;

endpackage

/* src/mjm_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a tag alongside the data; depends on nothing else.
module mjm_div_pipe #(
   parameter int NUM_W = 8,
   parameter int DEN_W = 8,
   parameter int QUO_W = 8,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic [QUO_W-1:0] en_i,
   input  logic [NUM_W-1:0] num_i,
   input  logic [DEN_W-1:0] den_i,
   input  logic [TAG_W-1:0] tag_i,
   output logic [QUO_W-1:0] quo_o,
   output logic [TAG_W-1:0] tag_o
);

   localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [CW-1:0]    rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [TAG_W-1:0] tag_ff [QUO_W];

   // The quotient is known to fit in QUO_W bits, so the first stage may
   // start at the top quotient bit.
   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int BIT = QUO_W - 1 - k;
      logic [CW-1:0]    rem_src;
      logic [CW-1:0]    trial;
      logic [CW-1:0]    rem_in;
      logic [DEN_W-1:0] den_src;
      logic [QUO_W-1:0] quo_src;
      logic [QUO_W-1:0] quo_in;
      logic [TAG_W-1:0] tag_src;

      if (k == 0) begin : g_first
         assign rem_src = CW'(num_i);
         assign den_src = den_i;
         assign quo_src = '0;
         assign tag_src = tag_i;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign tag_src = tag_ff[k-1];
      end

      assign trial = CW'(den_src) << BIT;

      always_comb begin
         rem_in = rem_src;
         quo_in = quo_src;
         if (rem_src >= trial) begin
            rem_in      = rem_src - trial;
            quo_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en_i[k]) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            quo_ff[k] <= quo_in;
            tag_ff[k] <= tag_src;
         end
      end
   end

   assign quo_o = quo_ff[QUO_W-1];
   assign tag_o = tag_ff[QUO_W-1];

endmodule

/* src/mjm_front.sv */
// Front end: dead zone, axis snapping and the four wheel sums, two stages.
// Depends on mjm_pkg.
module mjm_front
   import mjm_pkg::*;
(
   input  logic                     clock,
   input  logic [1:0]               en_i,
   input  cfg_type                  cfg_i,
   input  logic signed [AXIS_W-1:0] fwd_i,
   input  logic signed [AXIS_W-1:0] str_i,
   input  logic signed [AXIS_W-1:0] trn_i,
   output sum_type                  sum_o [NUM_WHEELS]
);

   function automatic logic [ABS_W-1:0] axis_mag(input logic signed [AXIS_W-1:0] a);
      logic [AXIS_W-1:0] n;
      n = -a;
      return a[AXIS_W-1] ? n : a;
   endfunction

   logic signed [AXIS_W-1:0] y_in, x_in, t_in, y_ff, x_ff, t_ff;
   logic [ABS_W-1:0]         ya_in, xa_in, ya_ff, xa_ff;
   logic [ABS_W-1:0]         ym, xm, tm, dz, snap;
   logic                     snap_x, snap_y;
   sum_type                  ys, xs, ts;
   sum_type                  sum_in [NUM_WHEELS];
   sum_type                  sum_ff [NUM_WHEELS];

   // Stage one: an axis whose magnitude is below the dead zone becomes zero.
   always_comb begin
      dz    = ABS_W'(cfg_i.dead_zone);
      ym    = axis_mag(fwd_i);
      xm    = axis_mag(str_i);
      tm    = axis_mag(trn_i);
      y_in  = (ym < dz) ? '0 : fwd_i;
      x_in  = (xm < dz) ? '0 : str_i;
      t_in  = (tm < dz) ? '0 : trn_i;
      ya_in = (ym < dz) ? '0 : ym;
      xa_in = (xm < dz) ? '0 : xm;
   end

   always_ff @(posedge clock) begin
      if (en_i[0]) begin
         y_ff  <= y_in;
         x_ff  <= x_in;
         t_ff  <= t_in;
         ya_ff <= ya_in;
         xa_ff <= xa_in;
      end
   end

   // Stage two: snapping keeps only the dominant translation axis, and
   // equality with the snap level never snaps.
   always_comb begin
      snap   = ABS_W'(cfg_i.snap_level);
      snap_x = (ya_ff > snap) && (xa_ff < snap);
      snap_y = !snap_x && (xa_ff > snap) && (ya_ff < snap);
      ys     = snap_y ? '0 : SUM_W'(y_ff);
      xs     = snap_x ? '0 : SUM_W'(x_ff);
      ts     = SUM_W'(t_ff);
      sum_in[WHEEL_FL] = ys - ts - xs;
      sum_in[WHEEL_FR] = ys + ts + xs;
      sum_in[WHEEL_RL] = ts - ys - xs;
      sum_in[WHEEL_RR] = ys + ts - xs;
   end

   always_ff @(posedge clock) begin
      if (en_i[1]) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_o = sum_ff;

endmodule

/* src/mjm_norm.sv */
// Normalizer front: wheel magnitudes, their maximum and the operands of the
// first divider, two stages. Depends on mjm_pkg.
module mjm_norm
   import mjm_pkg::*;
#(
   parameter int MIX_LIMIT = MIX_LIMIT_DEF
) (
   input  logic                  clock,
   input  logic [1:0]            en_i,
   input  sum_type               sum_i [NUM_WHEELS],
   output logic [MAG_W+$clog2(MIX_LIMIT+1)-1:0] num_o [NUM_WHEELS],
   output logic [((MAG_W > $clog2(MIX_LIMIT+1)) ? MAG_W : $clog2(MIX_LIMIT+1))-1:0] den_o,
   output logic [NUM_WHEELS-1:0] neg_o
);

   localparam int LIM_W  = $clog2(MIX_LIMIT + 1);
   localparam int NUM1_W = MAG_W + LIM_W;
   localparam int DEN1_W = (MAG_W > LIM_W) ? MAG_W : LIM_W;

   mag_type                  mag_in [NUM_WHEELS];
   mag_type                  mag_ff [NUM_WHEELS];
   logic [NUM_WHEELS-1:0]    neg_in, neg_ff, neg2_ff;
   mag_type                  m01, m23, mx;
   logic [DEN1_W-1:0]        lim_d, mx_d;
   logic [DEN1_W-1:0]        den_in, den_ff;
   logic [NUM1_W-1:0]        lim_n;
   logic [NUM1_W-1:0]        num_in [NUM_WHEELS];
   logic [NUM1_W-1:0]        num_ff [NUM_WHEELS];

   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         sum_type n;
         n         = -sum_i[i];
         neg_in[i] = sum_i[i][SUM_W-1];
         mag_in[i] = neg_in[i] ? n[MAG_W-1:0] : sum_i[i][MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_i[0]) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   // When no sum is over the limit the divisor is the limit itself, so the
   // first divider hands the magnitude through unchanged.
   always_comb begin
      m01    = (mag_ff[WHEEL_FL] > mag_ff[WHEEL_FR]) ? mag_ff[WHEEL_FL] : mag_ff[WHEEL_FR];
      m23    = (mag_ff[WHEEL_RL] > mag_ff[WHEEL_RR]) ? mag_ff[WHEEL_RL] : mag_ff[WHEEL_RR];
      mx     = (m01 > m23) ? m01 : m23;
      lim_d  = DEN1_W'(MIX_LIMIT);
      mx_d   = DEN1_W'(mx);
      den_in = (mx_d > lim_d) ? mx_d : lim_d;
      lim_n  = NUM1_W'(MIX_LIMIT);
      for (int i = 0; i < NUM_WHEELS; i++) begin
         num_in[i] = NUM1_W'(mag_ff[i]) * lim_n;
      end
   end

   always_ff @(posedge clock) begin
      if (en_i[1]) begin
         num_ff  <= num_in;
         den_ff  <= den_in;
         neg2_ff <= neg_ff;
      end
   end

   assign num_o = num_ff;
   assign den_o = den_ff;
   assign neg_o = neg2_ff;

endmodule

/* src/mecanum_joystick_mixer.sv */
// Mecanum joystick mixer, top level: registers, pipeline control, scaling.
// The pipeline has $clog2(MIX_LIMIT+1) + 7 register stages (17 at MIX_LIMIT 512). A result
// is offered from the last stage and held there until rsp_ready takes it. One item per cycle
// unless the output stalls. The limiting divider, one quotient bit per stage, sets the depth.
// A stage advances when it is empty or the stage after it advances, so bubbles close up.
// Reset clears all valid bits and loads the register defaults.
module mecanum_joystick_mixer
   import mjm_pkg::*;
#(
   parameter int MIX_LIMIT = MIX_LIMIT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [AXIS_W-1:0] req_forward_axis,
   input  logic signed [AXIS_W-1:0] req_strafe_axis,
   input  logic signed [AXIS_W-1:0] req_turn_axis,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [DUTY_W-1:0]        rsp_front_left_duty,
   output logic                     rsp_front_left_forward,
   output logic [DUTY_W-1:0]        rsp_front_right_duty,
   output logic                     rsp_front_right_forward,
   output logic [DUTY_W-1:0]        rsp_rear_left_duty,
   output logic                     rsp_rear_left_forward,
   output logic [DUTY_W-1:0]        rsp_rear_right_duty,
   output logic                     rsp_rear_right_forward,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int LIM_W  = $clog2(MIX_LIMIT + 1);
   localparam int NUM1_W = MAG_W + LIM_W;
   localparam int DEN1_W = (MAG_W > LIM_W) ? MAG_W : LIM_W;
   localparam int PRD_W  = LIM_W + PWM_W;
   localparam int RCP_W  = PRD_W + 2;
   localparam int RPR_W  = PRD_W + RCP_W;
   localparam int RCP_SH = PRD_W + LIM_W;
   localparam int P_DIV1 = 4;
   localparam int P_MUL  = P_DIV1 + LIM_W;
   localparam int P_RCP  = P_MUL + 1;
   localparam int P_OUT  = P_RCP + 1;
   localparam int NS     = P_OUT + 1;

   // Rounded-up reciprocal of the mixing limit with RCP_SH fraction bits. The
   // rounding error stays below one part in 2**LIM_W of any product that can
   // reach it, so the shifted product is the exact truncated quotient.
   localparam logic [RCP_W-1:0] RCP =
      RCP_W'(((64'd1 << RCP_SH) + 64'(MIX_LIMIT) - 64'd1) / 64'(MIX_LIMIT));

   cfg_type cfg_ff, cfg_in;

   logic [NS-1:0] valid_ff, valid_in, en;

   sum_type               sum [NUM_WHEELS];
   logic [NUM1_W-1:0]     num1 [NUM_WHEELS];
   logic [DEN1_W-1:0]     den1;
   logic [NUM_WHEELS-1:0] neg1, neg_q1, negm_ff, negr_ff, fwd_in, fwd_ff;
   logic [LIM_W-1:0]      q1 [NUM_WHEELS];
   logic [PRD_W-1:0]      prd_ff [NUM_WHEELS];
   logic [RPR_W-1:0]      rpr_ff [NUM_WHEELS];
   logic [DUTY_W-1:0]     duty_in [NUM_WHEELS];
   logic [DUTY_W-1:0]     duty_ff [NUM_WHEELS];

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DEAD_ZONE:  cfg_in.dead_zone      = csr_wdata[DZ_W-1:0];
            CSR_SNAP_LEVEL: cfg_in.snap_level     = csr_wdata[DZ_W-1:0];
            CSR_PWM_FULL:   cfg_in.pwm_full_scale = csr_wdata[PWM_W-1:0];
            CSR_INVERT:     cfg_in.invert_mask    = csr_wdata[NUM_WHEELS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_zone      <= DEAD_ZONE_RST;
         cfg_ff.snap_level     <= SNAP_LEVEL_RST;
         cfg_ff.pwm_full_scale <= PWM_FULL_RST;
         cfg_ff.invert_mask    <= INVERT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline control: each stage loads when it is empty or its item moves on.
   assign en[NS-1] = !valid_ff[NS-1] || rsp_ready;
   for (genvar k = 0; k < NS - 1; k++) begin : g_en
      assign en[k] = !valid_ff[k] || en[k+1];
   end

   always_comb begin
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[NS-1];

   mjm_front u_front (
      .clock (clock),
      .en_i  (en[1:0]),
      .cfg_i (cfg_ff),
      .fwd_i (req_forward_axis),
      .str_i (req_strafe_axis),
      .trn_i (req_turn_axis),
      .sum_o (sum)
   );

   mjm_norm #(
      .MIX_LIMIT (MIX_LIMIT)
   ) u_norm (
      .clock (clock),
      .en_i  (en[3:2]),
      .sum_i (sum),
      .num_o (num1),
      .den_o (den1),
      .neg_o (neg1)
   );

   for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_wheel
      // Limit the sum to the mixing range: magnitude * limit / max(largest, limit).
      mjm_div_pipe #(
         .NUM_W (NUM1_W),
         .DEN_W (DEN1_W),
         .QUO_W (LIM_W),
         .TAG_W (1)
      ) u_div_lim (
         .clock (clock),
         .en_i  (en[P_DIV1 +: LIM_W]),
         .num_i (num1[i]),
         .den_i (den1),
         .tag_i (neg1[i]),
         .quo_o (q1[i]),
         .tag_o (neg_q1[i])
      );

      always_ff @(posedge clock) begin
         if (en[P_MUL]) begin
            prd_ff[i]  <= PRD_W'(q1[i]) * PRD_W'(cfg_ff.pwm_full_scale);
            negm_ff[i] <= neg_q1[i];
         end
      end

      // Map the mixing range onto the PWM range by multiplying with the reciprocal.
      always_ff @(posedge clock) begin
         if (en[P_RCP]) begin
            rpr_ff[i]  <= RPR_W'(prd_ff[i]) * RPR_W'(RCP);
            negr_ff[i] <= negm_ff[i];
         end
      end

      assign duty_in[i] = rpr_ff[i][RCP_SH +: DUTY_W];

      // A zero command always reads as forward, inverted or not.
      assign fwd_in[i] = !(negr_ff[i] ^ cfg_ff.invert_mask[i]) || (duty_in[i] == '0);

      always_ff @(posedge clock) begin
         if (en[P_OUT]) begin
            duty_ff[i] <= duty_in[i];
            fwd_ff[i]  <= fwd_in[i];
         end
      end
   end

   assign rsp_front_left_duty     = duty_ff[WHEEL_FL];
   assign rsp_front_left_forward  = fwd_ff[WHEEL_FL];
   assign rsp_front_right_duty    = duty_ff[WHEEL_FR];
   assign rsp_front_right_forward = fwd_ff[WHEEL_FR];
   assign rsp_rear_left_duty      = duty_ff[WHEEL_RL];
   assign rsp_rear_left_forward   = fwd_ff[WHEEL_RL];
   assign rsp_rear_right_duty     = duty_ff[WHEEL_RR];
   assign rsp_rear_right_forward  = fwd_ff[WHEEL_RR];

`ifndef SYNTH
   a_accept_fills_first: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> valid_ff[0])
      else $error("accepted item did not reach the first stage");

   a_limit_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[P_MUL-1] |-> (q1[WHEEL_FL] <= LIM_W'(MIX_LIMIT)) &&
                            (q1[WHEEL_FR] <= LIM_W'(MIX_LIMIT)) &&
                            (q1[WHEEL_RL] <= LIM_W'(MIX_LIMIT)) &&
                            (q1[WHEEL_RR] <= LIM_W'(MIX_LIMIT)))
      else $error("limited wheel magnitude exceeds the mixing range");

   a_zero_forward: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_front_left_duty != '0) || rsp_front_left_forward) &&
                    ((rsp_front_right_duty != '0) || rsp_front_right_forward) &&
                    ((rsp_rear_left_duty != '0) || rsp_rear_left_forward) &&
                    ((rsp_rear_right_duty != '0) || rsp_rear_right_forward))
      else $error("zero duty reported with reverse direction");

   a_stall_holds_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid &&
         $stable({rsp_front_left_duty, rsp_front_left_forward,
                  rsp_front_right_duty, rsp_front_right_forward,
                  rsp_rear_left_duty, rsp_rear_left_forward,
                  rsp_rear_right_duty, rsp_rear_right_forward}))
      else $error("output item changed while it was stalled");
`endif

endmodule
